>>> rtl/core/record_insertion_sorter_core_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the record insertion sorter
// Shared property wrappers used by the checker; clock and reset come from the
// scope that uses them.
// ----------------------------------------------------------------------------
`ifndef RECORD_INSERTION_SORTER_CORE_ASSERT_SVH
`define RECORD_INSERTION_SORTER_CORE_ASSERT_SVH

// Property checked only while reset is released.
`define RIS_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("record sorter check failed");

// Property checked at every edge, reset included.
`define RIS_ASSERT_RST(lbl, prop) \
  lbl: assert property (@(posedge clk_i) prop) \
    else $error("record sorter reset check failed");

`endif

>>> rtl/core/ris_pkg.sv
// ----------------------------------------------------------------------------
// ris_pkg
// Types shared by the record insertion sorter modules.
// ----------------------------------------------------------------------------
package ris_pkg;

  // One stored record: payload fields plus the arrival position.
  typedef struct packed {
    logic [31:0] date;
    logic [31:0] owner;
    logic [63:0] price;
    logic [63:0] amount;
    logic [5:0]  origin;
  } rec_t;

  localparam int unsigned RecW = $bits(rec_t);

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load_in;     // capture the incoming request
    logic rd_prev;     // read the slot below the insertion index
    logic shift_wr;    // move the slot just read up by one
    logic ins_wr;      // write the new record at the insertion index
    logic start_emit;  // rewind the index for output
    logic rd_idx;      // read the slot at the index
    logic out_load;    // move the read slot into the output register
    logic out_empty;   // load the "no records" result
    logic clear;       // return both counts to zero
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic store;       // the captured record goes into the store
    logic last;        // the captured record ends the list
    logic idx_zero;    // insertion index reached the bottom
    logic greater;     // slot just read has a larger amount
    logic filled_zero; // nothing stored
    logic emit_last;   // index points at the last stored record
    logic out_free;    // output register can take a result
  } sts_t;

endpackage

>>> rtl/core/ris_if.sv
// ----------------------------------------------------------------------------
// Record sorter channels
// Valid/ready channels for incoming trade records and sorted results.
// ----------------------------------------------------------------------------
interface ris_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] rec_date;
  logic signed [31:0] rec_owner;
  logic signed [63:0] rec_price;
  logic signed [63:0] rec_amount;
  logic               end_of_list;

  modport source (
    output valid, rec_date, rec_owner, rec_price, rec_amount, end_of_list,
    input  ready
  );
  modport sink (
    input  valid, rec_date, rec_owner, rec_price, rec_amount, end_of_list,
    output ready
  );
endinterface

interface ris_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] out_date;
  logic signed [31:0] out_owner;
  logic signed [63:0] out_price;
  logic signed [63:0] out_amount;
  logic [5:0]         origin_pos;
  logic               rec_valid;
  logic               final_out;

  modport source (
    output valid, out_date, out_owner, out_price, out_amount, origin_pos,
           rec_valid, final_out,
    input  ready
  );
  modport sink (
    input  valid, out_date, out_owner, out_price, out_amount, origin_pos,
           rec_valid, final_out,
    output ready
  );
endinterface

>>> rtl/core/record_insertion_sorter_core.sv
// ----------------------------------------------------------------------------
// record_insertion_sorter_core
// Stable insertion sorter for trade records, ordered by ascending amount.
// ----------------------------------------------------------------------------
//
//  Channel  Direction  Request carries
//  -------  ---------  -----------------------------------------------------
//  req_i    in         one trade record plus the end-of-list mark
//  res_o    out        one sorted record with arrival position and flags
//
// A record that is stored walks down from the fill count: for each stored
// record with a larger amount the slot below the index is read and then
// written one slot up, and the record is written where the walk stops; a
// record that is not stored is dropped. The single read port of the record
// memory makes each shift one read and one write. On the end-of-list mark
// each result is a memory read, then an output load, while the sink is
// ready. Reset clears the counts and the controller; the memory is not
// cleared, since only slots below the fill count are ever read.
// A stalled sink holds the output register and pauses the emit sequence;
// new requests are taken again as soon as the last result is loaded.
//
module record_insertion_sorter_core #(
  parameter int unsigned ENTRIES = 64
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  ris_in_if.sink     req_i,
  ris_out_if.source  res_o
);

  // Commands and status between the sequencer and the datapath.
  ris_pkg::cmd_t cmd;
  ris_pkg::sts_t sts;

  // The sequencer owns the request handshake: it takes a request only when
  // the previous one has been fully inserted and any emit has been loaded.
  ris_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(req_i.valid),
    .in_ready_o(req_i.ready),
    .cmd_o     (cmd),
    .sts_i     (sts)
  );

  // The datapath holds the sorted record memory, the arrival and fill
  // counts, the key comparator and the output register.
  ris_datapath #(
    .ENTRIES(ENTRIES)
  ) u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .rec_date_i   (req_i.rec_date),
    .rec_owner_i  (req_i.rec_owner),
    .rec_price_i  (req_i.rec_price),
    .rec_amount_i (req_i.rec_amount),
    .end_of_list_i(req_i.end_of_list),
    .out_ready_i  (res_o.ready),
    .out_valid_o  (res_o.valid),
    .out_date_o   (res_o.out_date),
    .out_owner_o  (res_o.out_owner),
    .out_price_o  (res_o.out_price),
    .out_amount_o (res_o.out_amount),
    .origin_pos_o (res_o.origin_pos),
    .rec_valid_o  (res_o.rec_valid),
    .final_out_o  (res_o.final_out)
  );

endmodule

>>> rtl/core/ris_ram.sv
// ----------------------------------------------------------------------------
// ris_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module ris_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> rtl/core/ris_datapath.sv
// ----------------------------------------------------------------------------
// ris_datapath
// Record store, counters, key compare and output register of the sorter.
// ----------------------------------------------------------------------------
module ris_datapath #(
  parameter int unsigned ENTRIES = 64
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  ris_pkg::cmd_t      cmd_i,
  output ris_pkg::sts_t      sts_o,
  input  logic signed [31:0] rec_date_i,
  input  logic signed [31:0] rec_owner_i,
  input  logic signed [63:0] rec_price_i,
  input  logic signed [63:0] rec_amount_i,
  input  logic               end_of_list_i,
  input  logic               out_ready_i,
  output logic               out_valid_o,
  output logic signed [31:0] out_date_o,
  output logic signed [31:0] out_owner_o,
  output logic signed [63:0] out_price_o,
  output logic signed [63:0] out_amount_o,
  output logic [5:0]         origin_pos_o,
  output logic               rec_valid_o,
  output logic               final_out_o
);

  localparam int unsigned AW = $clog2(ENTRIES);
  localparam int unsigned CW = $clog2(ENTRIES + 1);
  localparam logic [CW-1:0] Full = CW'(ENTRIES);

  ris_pkg::rec_t new_q;
  logic          store_q, last_q;
  logic [CW-1:0] arrival_q, filled_q, idx_q;
  logic [CW-1:0] idx_m1, idx_p1;
  logic          empty_rec;

  ris_pkg::rec_t rdata, wdata;
  logic [AW-1:0] raddr;

  logic          out_valid_q, rec_valid_q, final_q;
  ris_pkg::rec_t out_q;

  assign idx_m1 = idx_q - 1'b1;
  assign idx_p1 = idx_q + 1'b1;

  // A record is empty when every field is zero or negative.
  assign empty_rec = (rec_date_i <= 0) && (rec_owner_i <= 0) &&
                     (rec_price_i <= 0) && (rec_amount_i <= 0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      store_q   <= 1'b0;
      last_q    <= 1'b0;
      arrival_q <= '0;
      filled_q  <= '0;
      idx_q     <= '0;
    end else begin
      if (cmd_i.load_in) begin
        last_q  <= end_of_list_i;
        store_q <= (arrival_q < Full) && !empty_rec && (filled_q < Full);
        idx_q   <= filled_q;
        if (arrival_q < Full) begin
          arrival_q <= arrival_q + 1'b1;
        end
      end
      if (cmd_i.shift_wr) begin
        idx_q <= idx_m1;
      end
      if (cmd_i.ins_wr) begin
        filled_q <= filled_q + 1'b1;
      end
      if (cmd_i.start_emit) begin
        idx_q <= '0;
      end
      if (cmd_i.out_load) begin
        idx_q <= idx_p1;
      end
      if (cmd_i.clear) begin
        filled_q  <= '0;
        arrival_q <= '0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      new_q.date   <= rec_date_i;
      new_q.owner  <= rec_owner_i;
      new_q.price  <= rec_price_i;
      new_q.amount <= rec_amount_i;
      new_q.origin <= 6'(arrival_q);
    end
  end

  assign wdata = cmd_i.shift_wr ? rdata : new_q;
  assign raddr = cmd_i.rd_prev ? idx_m1[AW-1:0] : idx_q[AW-1:0];

  ris_ram #(
    .Width(ris_pkg::RecW),
    .Depth(ENTRIES)
  ) u_store (
    .clk_i  (clk_i),
    .we_i   (cmd_i.shift_wr | cmd_i.ins_wr),
    .waddr_i(idx_q[AW-1:0]),
    .wdata_i(wdata),
    .re_i   (cmd_i.rd_prev | cmd_i.rd_idx),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  // Output register: holds one result until the consumer takes it.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load || cmd_i.out_empty) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_q       <= rdata;
      rec_valid_q <= 1'b1;
      final_q     <= (idx_p1 == filled_q);
    end else if (cmd_i.out_empty) begin
      out_q       <= '0;
      rec_valid_q <= 1'b0;
      final_q     <= 1'b1;
    end
  end

  assign sts_o.store       = store_q;
  assign sts_o.last        = last_q;
  assign sts_o.idx_zero    = (idx_q == '0);
  assign sts_o.greater     = $signed(rdata.amount) > $signed(new_q.amount);
  assign sts_o.filled_zero = (filled_q == '0);
  assign sts_o.emit_last   = (idx_p1 == filled_q);
  assign sts_o.out_free    = !out_valid_q || out_ready_i;

  assign out_valid_o  = out_valid_q;
  assign out_date_o   = out_q.date;
  assign out_owner_o  = out_q.owner;
  assign out_price_o  = out_q.price;
  assign out_amount_o = out_q.amount;
  assign origin_pos_o = out_q.origin;
  assign rec_valid_o  = rec_valid_q;
  assign final_out_o  = final_q;

endmodule

>>> rtl/core/ris_ctrl.sv
// ----------------------------------------------------------------------------
// ris_ctrl
// Sequencer for capture, insertion shifting and sorted output.
// ----------------------------------------------------------------------------
module ris_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  output ris_pkg::cmd_t cmd_o,
  input  ris_pkg::sts_t sts_i
);

  typedef enum logic [4:0] {
    ST_IDLE     = 5'b00001,
    ST_SCAN     = 5'b00010,
    ST_CMP      = 5'b00100,
    ST_EMIT_RD  = 5'b01000,
    ST_EMIT_OUT = 5'b10000
  } state_e;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load_in = 1'b1;
          state_d       = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (sts_i.store && !sts_i.idx_zero) begin
          cmd_o.rd_prev = 1'b1;
          state_d       = ST_CMP;
        end else begin
          cmd_o.ins_wr = sts_i.store;
          if (sts_i.last) begin
            cmd_o.start_emit = 1'b1;
            state_d          = ST_EMIT_RD;
          end else begin
            state_d = ST_IDLE;
          end
        end
      end
      ST_CMP: begin
        if (sts_i.greater) begin
          cmd_o.shift_wr = 1'b1;
          state_d        = ST_SCAN;
        end else begin
          cmd_o.ins_wr = 1'b1;
          if (sts_i.last) begin
            cmd_o.start_emit = 1'b1;
            state_d          = ST_EMIT_RD;
          end else begin
            state_d = ST_IDLE;
          end
        end
      end
      ST_EMIT_RD: begin
        if (sts_i.filled_zero) begin
          if (sts_i.out_free) begin
            cmd_o.out_empty = 1'b1;
            cmd_o.clear     = 1'b1;
            state_d         = ST_IDLE;
          end
        end else begin
          cmd_o.rd_idx = 1'b1;
          state_d      = ST_EMIT_OUT;
        end
      end
      ST_EMIT_OUT: begin
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          if (sts_i.emit_last) begin
            cmd_o.clear = 1'b1;
            state_d     = ST_IDLE;
          end else begin
            state_d = ST_EMIT_RD;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

>>> rtl/core/ris_checker.sv
// ----------------------------------------------------------------------------
// ris_checker
// Port-level checks of the sorter result channel, bound to the top level.
// ----------------------------------------------------------------------------
`include "record_insertion_sorter_core_assert.svh"

module ris_checker #(
  parameter int unsigned ENTRIES = 64
) (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic [63:0] out_amount_i,
  input logic [5:0]  origin_pos_i,
  input logic        rec_valid_i,
  input logic        final_out_i
);

  // A pending result stays offered, and its amount unchanged, until it is taken.
  `RIS_ASSERT(a_out_hold, out_valid_i && !out_ready_i |=> out_valid_i)
  `RIS_ASSERT(a_out_stable, out_valid_i && !out_ready_i |=> $stable(out_amount_i))

  // The "no records" result is always the only, and so final, one.
  `RIS_ASSERT(a_empty_final, out_valid_i && !rec_valid_i |-> final_out_i && origin_pos_i == 0)

  // A real record always comes from inside the stored range.
  `RIS_ASSERT(a_origin_range, out_valid_i && rec_valid_i |-> $unsigned(origin_pos_i) < ENTRIES)

  // Nothing is offered right after reset.
  `RIS_ASSERT_RST(a_reset_quiet, !rst_ni |=> !out_valid_i)

endmodule

bind record_insertion_sorter_core ris_checker #(
  .ENTRIES(ENTRIES)
) u_ris_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_i (res_o.valid),
  .out_ready_i (res_o.ready),
  .out_amount_i(res_o.out_amount),
  .origin_pos_i(res_o.origin_pos),
  .rec_valid_i (res_o.rec_valid),
  .final_out_i (res_o.final_out)
);
